### rtl/core/kafq_pkg.sv
// ----------------------------------------------------------------------------
// kafq_pkg
// shared types, widths and codes of the keyframe aware frame queue
// ----------------------------------------------------------------------------
package kafq_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int PTR_W      = $clog2(MAX_FRAMES);
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

   // fixed field widths
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 3;
   localparam int ADDR_W    = 32;
   localparam int LENGTH_W  = 24;
   localparam int TIME_W    = 64;
   localparam int LEVEL_W   = 7;
   localparam int DROPS_W   = 32;
   localparam int CAP_W     = 7;
   localparam int EXT_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH          = 3'd0,
      OP_PUSH_DROP     = 3'd1,
      OP_PEEK          = 3'd2,
      OP_RELEASE       = 3'd3,
      OP_DROP_OLDEST   = 3'd4,
      OP_DROP_NON_KEY  = 3'd5,
      OP_CLEAR_DROPS   = 3'd6
   } op_type;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOKEY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [LENGTH_W-1:0] length;
      logic [TIME_W-1:0]   stamp;
      logic                key;
   } entry_type;

   typedef struct packed {
      op_type    op;
      entry_type entry;
   } item_type;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [PTR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      entry_type           head;
      logic [LEVEL_W-1:0]  level;
      logic                full;
      logic                empty;
      logic [DROPS_W-1:0]  drops;
   } result_type;

endpackage

### rtl/core/kafq_store.sv
// ----------------------------------------------------------------------------
// kafq_store
// descriptor memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module kafq_store
   import kafq_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rdata
);

   entry_type mem_ff [MAX_FRAMES];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/kafq_ctrl.sv
// ----------------------------------------------------------------------------
// kafq_ctrl
// operation sequencer: ring pointers, level, drop count, search and shift
// ----------------------------------------------------------------------------
module kafq_ctrl
   import kafq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  item_type         item,
   input  logic             cfg_clear,
   input  logic [CNT_W-1:0] cap_eff,
   input  logic             out_free,
   input  entry_type        rdata,
   output logic             idle,
   output logic             res_valid,
   output result_type       result,
   output mem_req_type      mem_req
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SHF_RD,
      S_SHF_WR,
      S_HEAD_RD,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [PTR_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [DROPS_W-1:0]  drops_ff, drops_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   item_type            item_ff, item_in;
   logic                full;
   logic                empty;

   function automatic logic [PTR_W-1:0] ptr_fwd(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + CNT_W'(1);
      if (n >= cap) begin
         return '0;
      end
      return n[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] last;
      last = cap - CNT_W'(1);
      if (p == '0) begin
         return last[PTR_W-1:0];
      end
      return p - PTR_W'(1);
   endfunction

   assign full  = (count_ff >= cap_eff);
   assign empty = (count_ff == '0);
   assign idle  = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      steps_in  = steps_ff;
      drops_in  = drops_ff;
      status_in = status_ff;
      item_in   = item_ff;
      mem_req   = '0;
      res_valid = 1'b0;

      result.status = status_ff;
      result.head   = empty ? '0 : rdata;
      result.level  = LEVEL_W'(count_ff);
      result.full   = full;
      result.empty  = empty;
      result.drops  = drops_ff;

      if (cfg_clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in   = item;
               status_in = ST_OK;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_HEAD_RD;
            case (item_ff.op)
               OP_PUSH: begin
                  if (full) begin
                     drops_in  = drops_ff + DROPS_W'(1);
                     status_in = ST_FULL;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = tail_ff;
                     mem_req.wdata = item_ff.entry;
                     tail_in       = ptr_fwd(tail_ff, cap_eff);
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               OP_PUSH_DROP: begin
                  // when full the tail sits on the head: overwrite it, level unchanged
                  mem_req.we    = 1'b1;
                  mem_req.waddr = tail_ff;
                  mem_req.wdata = item_ff.entry;
                  tail_in       = ptr_fwd(tail_ff, cap_eff);
                  if (full) begin
                     drops_in  = drops_ff + DROPS_W'(1);
                     head_in   = ptr_fwd(head_ff, cap_eff);
                     status_in = ST_DROPPED;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_PEEK: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end
               end
               OP_RELEASE, OP_DROP_OLDEST: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     head_in  = ptr_fwd(head_ff, cap_eff);
                     count_in = count_ff - CNT_W'(1);
                     if (item_ff.op == OP_DROP_OLDEST) begin
                        drops_in = drops_ff + DROPS_W'(1);
                     end
                  end
               end
               OP_DROP_NON_KEY: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     pos_in   = head_ff;
                     steps_in = '0;
                     state_in = S_SRCH_RD;
                  end
               end
               OP_CLEAR_DROPS: begin
                  drops_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_SRCH_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = pos_ff;
            state_in      = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (!rdata.key) begin
               if (steps_ff == '0) begin
                  drops_in = drops_ff + DROPS_W'(1);
                  head_in  = ptr_fwd(head_ff, cap_eff);
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_HEAD_RD;
               end else begin
                  state_in = S_SHF_RD;
               end
            end else if (steps_ff + CNT_W'(1) == count_ff) begin
               status_in = ST_NOKEY;
               state_in  = S_HEAD_RD;
            end else begin
               pos_in   = ptr_fwd(pos_ff, cap_eff);
               steps_in = steps_ff + CNT_W'(1);
               state_in = S_SRCH_RD;
            end
         end
         S_SHF_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ptr_back(pos_ff, cap_eff);
            state_in      = S_SHF_WR;
         end
         S_SHF_WR: begin
            // copy the older neighbor one slot toward the tail
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            mem_req.wdata = rdata;
            pos_in        = ptr_back(pos_ff, cap_eff);
            steps_in      = steps_ff - CNT_W'(1);
            if (steps_ff == CNT_W'(1)) begin
               drops_in = drops_ff + DROPS_W'(1);
               head_in  = ptr_fwd(head_ff, cap_eff);
               count_in = count_ff - CNT_W'(1);
               state_in = S_HEAD_RD;
            end else begin
               state_in = S_SHF_RD;
            end
         end
         S_HEAD_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = head_ff;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         drops_ff  <= '0;
         pos_ff    <= '0;
         steps_ff  <= '0;
         status_ff <= ST_OK;
         item_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         drops_ff  <= drops_in;
         pos_ff    <= pos_in;
         steps_ff  <= steps_in;
         status_ff <= status_in;
         item_ff   <= item_in;
      end
   end

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("queue level exceeds capacity");

   a_ptrs_in_range: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(head_ff) < cap_eff) && (CNT_W'(tail_ff) < cap_eff))
      else $error("ring pointer outside capacity");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && (count_ff == '0 || count_ff == cap_eff))
      |-> (head_ff == tail_ff))
      else $error("head and tail disagree with level");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_req.we)
      else $error("memory write outside an operation");

endmodule

### rtl/core/keyframe_aware_frame_queue_unit.sv
// ----------------------------------------------------------------------------
// keyframe_aware_frame_queue_unit
// every operation steps through idle, execute, head read and done, then loads
//   the output register once it is free; drop_first_non_key adds a read and a
//   check per entry searched, a read and a write per entry shifted, one memory
//   access a cycle; a new request is taken only once the controller is idle,
//   also while the previous response still waits in the output register
// reset: synchronous, empties the queue, clears drops, capacity back to 64
// ----------------------------------------------------------------------------
module keyframe_aware_frame_queue_unit
   import kafq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [ADDR_W-1:0]   req_buffer_addr,
   input  logic [LENGTH_W-1:0] req_frame_length,
   input  logic [TIME_W-1:0]   req_frame_time,
   input  logic                req_key_frame,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_head_addr,
   output logic [LENGTH_W-1:0] rsp_head_length,
   output logic [TIME_W-1:0]   rsp_head_time,
   output logic                rsp_head_is_key,
   output logic [LEVEL_W-1:0]  rsp_level,
   output logic                rsp_is_full,
   output logic                rsp_is_empty,
   output logic [DROPS_W-1:0]  rsp_drops,
   // capacity register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_capacity
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [EXT_W-1:0] cap_ext;
   logic [CNT_W-1:0] cap_eff;
   logic             ctrl_idle;
   logic             start;
   logic             cfg_write;
   logic             out_free;
   logic             res_valid;
   item_type         item;
   result_type       result;
   mem_req_type      mem_req;
   entry_type        rdata;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;

   // capacity write wins over a request in the same cycle
   assign csr_ready = ctrl_idle;
   assign req_stall = !ctrl_idle || csr_valid;
   assign cfg_write = csr_valid && csr_ready;
   assign start     = req_valid && !req_stall;

   assign capacity_in = cfg_write ? csr_capacity : capacity_ff;

   // clamp to 1..MAX_FRAMES, zero acts as one
   assign cap_ext = EXT_W'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ext > EXT_W'(MAX_FRAMES)) begin
         cap_eff = CNT_W'(MAX_FRAMES);
      end else begin
         cap_eff = cap_ext[CNT_W-1:0];
      end
   end

   assign item.op           = op_type'(req_op);
   assign item.entry.addr   = req_buffer_addr;
   assign item.entry.length = req_frame_length;
   assign item.entry.stamp  = req_frame_time;
   assign item.entry.key    = req_key_frame;

   // output register frees up when its transaction is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   kafq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .cfg_clear (cfg_write),
      .cap_eff   (cap_eff),
      .out_free  (out_free),
      .rdata     (rdata),
      .idle      (ctrl_idle),
      .res_valid (res_valid),
      .result    (result),
      .mem_req   (mem_req)
   );

   kafq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   always_comb begin
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only into a free slot
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_head_addr   = rsp_ff.head.addr;
   assign rsp_head_length = rsp_ff.head.length;
   assign rsp_head_time   = rsp_ff.head.stamp;
   assign rsp_head_is_key = rsp_ff.head.key;
   assign rsp_level       = rsp_ff.level;
   assign rsp_is_full     = rsp_ff.full;
   assign rsp_is_empty    = rsp_ff.empty;
   assign rsp_drops       = rsp_ff.drops;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten before taken");

   a_no_start_with_cfg: assert property (@(posedge clock) disable iff (reset)
      cfg_write |-> !start)
      else $error("request accepted during capacity write");

endmodule
